/* src/acs_pkg.sv */
// ----------------------------------------------------------------------------
// ANSI CSI sequence stripper package
// Shared constants and the command type passed from front to back.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MAX_HOLD    = 32;
  localparam int HOLD_AW     = $clog2(MAX_HOLD);
  localparam int CNT_W       = $clog2(MAX_HOLD + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_ESC       = 8'h1b;
  localparam logic [7:0] CH_BRACKET   = 8'h5b;
  localparam logic [7:0] CH_PARAM_LO  = 8'h30;
  localparam logic [7:0] CH_PARAM_HI  = 8'h3f;
  localparam logic [7:0] CH_INTER_LO  = 8'h20;
  localparam logic [7:0] CH_INTER_HI  = 8'h2f;
  localparam logic [7:0] CH_FINAL_K   = 8'h4b;
  localparam logic [7:0] CH_FINAL_M   = 8'h6d;

  typedef struct packed {
    logic [7:0]       data;
    logic             emit_byte;
    logic [CNT_W-1:0] rel_count;
    logic             ov;
    logic             is_end;
  } cmd_t;

endpackage

/* src/acs_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one text byte and its end flag.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

/* src/acs_out_if.sv */
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one stripped result.
// ----------------------------------------------------------------------------
interface acs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;
  logic       hold_overflow;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_done, output hold_overflow, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input text_done, input hold_overflow, output ready);
endinterface

/* src/acs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/acs_front.sv */
// ----------------------------------------------------------------------------
// Stripper front end
// Accepts bytes, tracks the escape parser and issues release commands.
// ----------------------------------------------------------------------------
module acs_front
  import acs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  acs_in_if.sink             in_chan,
  input  logic               q_full,
  input  logic               rel_done,
  output logic               push,
  output cmd_t               push_cmd,
  output logic               ram_we,
  output logic [HOLD_AW-1:0] ram_waddr,
  output logic [7:0]         ram_wdata
);

  localparam logic [2:0] M_SEARCH = 3'd0;
  localparam logic [2:0] M_ESC    = 3'd1;
  localparam logic [2:0] M_PARAM  = 3'd2;
  localparam logic [2:0] M_INTER  = 3'd3;
  localparam logic [2:0] M_PASS   = 3'd4;

  localparam logic [1:0] V_HOLD  = 2'd0;
  localparam logic [1:0] V_DONE  = 2'd1;
  localparam logic [1:0] V_BREAK = 2'd2;

  logic [2:0]       mode, mode_next, hold_mode;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic             pending, pending_next;
  logic [1:0]       verdict;
  logic             accept;
  logic [7:0]       b;

  assign b              = in_chan.in_byte;
  assign in_chan.ready  = !pending && !q_full;
  assign accept         = in_chan.valid && in_chan.ready;
  assign ram_wdata      = b;

  always_comb begin
    verdict   = V_BREAK;
    hold_mode = mode;
    if (mode == M_ESC) begin
      if (b == CH_BRACKET) begin
        verdict   = V_HOLD;
        hold_mode = M_PARAM;
      end
    end else if (mode == M_PARAM && b >= CH_PARAM_LO && b <= CH_PARAM_HI) begin
      verdict = V_HOLD;
    end else if (b >= CH_INTER_LO && b <= CH_INTER_HI) begin
      verdict   = V_HOLD;
      hold_mode = M_INTER;
    end else if (b == CH_FINAL_K || b == CH_FINAL_M) begin
      verdict = V_DONE;
    end
  end

  always_comb begin
    mode_next       = mode;
    held_count_next = held_count;
    ram_we          = 1'b0;
    ram_waddr       = held_count[HOLD_AW-1:0];
    push_cmd        = '0;
    push_cmd.data   = b;
    push            = 1'b0;
    if (accept) begin
      unique case (mode)
        M_SEARCH: begin
          if (b == CH_ESC) begin
            ram_we          = 1'b1;
            ram_waddr       = '0;
            held_count_next = CNT_W'(1);
            mode_next       = M_ESC;
          end else begin
            push_cmd.emit_byte = 1'b1;
          end
        end
        M_PASS: begin
          push_cmd.emit_byte = 1'b1;
        end
        default: begin
          if (verdict != V_BREAK && held_count >= CNT_W'(MAX_HOLD)) begin
            push_cmd.rel_count = held_count;
            push_cmd.emit_byte = 1'b1;
            push_cmd.ov        = 1'b1;
            held_count_next    = '0;
            mode_next          = M_PASS;
          end else if (verdict == V_HOLD) begin
            ram_we          = 1'b1;
            held_count_next = held_count + CNT_W'(1);
            mode_next       = hold_mode;
          end else if (verdict == V_DONE) begin
            held_count_next = '0;
            mode_next       = M_SEARCH;
          end else begin
            push_cmd.rel_count = held_count;
            push_cmd.emit_byte = 1'b1;
            held_count_next    = '0;
            mode_next          = M_PASS;
          end
        end
      endcase
      if (in_chan.text_end) begin
        if (mode_next == M_ESC || mode_next == M_PARAM || mode_next == M_INTER) begin
          push_cmd.rel_count = held_count_next;
        end
        push_cmd.is_end = 1'b1;
        mode_next       = M_SEARCH;
        held_count_next = '0;
      end
      push = push_cmd.emit_byte || (push_cmd.rel_count != '0) || push_cmd.is_end;
    end
  end

  assign pending_next = (pending && !rel_done) || (push && push_cmd.rel_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_SEARCH;
      held_count <= '0;
      pending    <= 1'b0;
    end else begin
      mode       <= mode_next;
      held_count <= held_count_next;
      pending    <= pending_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_HOLD))
    else $error("held byte count exceeds the hold buffer");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (held_count < CNT_W'(MAX_HOLD) || mode == M_SEARCH))
    else $error("hold buffer written beyond its depth");

endmodule

/* src/acs_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module acs_cmd_queue
  import acs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full  = fill == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QUEUE_AW + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("command popped from an empty queue");

endmodule

/* src/acs_back.sv */
// ----------------------------------------------------------------------------
// Stripper back end
// Carries out commands: releases held bytes, emits bytes and end markers.
// ----------------------------------------------------------------------------
module acs_back
  import acs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               head,
  input  logic               q_empty,
  output logic               pop,
  output logic               rel_done,
  output logic               ram_re,
  output logic [HOLD_AW-1:0] ram_raddr,
  input  logic [7:0]         ram_rdata,
  acs_out_if.source          out_chan
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  cmd_t             cur, cur_next;
  logic             out_free, load, last_held;
  logic [7:0]       ld_byte;
  logic             ld_bv, ld_last, ld_done, ld_ov;

  assign out_free  = !out_chan.valid || out_chan.ready;
  assign last_held = (idx + CNT_W'(1)) == cur.rel_count;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cur_next   = cur;
    pop        = 1'b0;
    rel_done   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx[HOLD_AW-1:0];
    load       = 1'b0;
    ld_byte    = cur.data;
    ld_bv      = 1'b1;
    ld_last    = 1'b0;
    ld_done    = 1'b0;
    ld_ov      = cur.ov;
    unique case (state)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          pop      = 1'b1;
          cur_next = head;
          if (head.rel_count != '0) begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            idx_next   = '0;
            state_next = S_READ;
          end else begin
            load    = 1'b1;
            ld_byte = head.emit_byte ? head.data : 8'h00;
            ld_bv   = head.emit_byte;
            ld_last = 1'b1;
            ld_done = head.is_end;
            ld_ov   = head.emit_byte && head.ov;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          load    = 1'b1;
          ld_byte = ram_rdata;
          ld_last = last_held && !cur.emit_byte;
          ld_done = last_held && !cur.emit_byte && cur.is_end;
          if (!last_held) begin
            idx_next  = idx + CNT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_next[HOLD_AW-1:0];
          end else if (cur.emit_byte) begin
            state_next = S_BYTE;
          end else begin
            rel_done   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (out_free) begin
          load       = 1'b1;
          ld_last    = 1'b1;
          ld_done    = cur.is_end;
          rel_done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    if (load) begin
      out_chan.out_byte      <= ld_byte;
      out_chan.byte_valid    <= ld_bv;
      out_chan.run_last      <= ld_last;
      out_chan.text_done     <= ld_done;
      out_chan.hold_overflow <= ld_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_chan.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_chan.valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_chan.valid <= 1'b0;
      end
    end
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (idx < cur.rel_count))
    else $error("release index beyond the held byte count");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && ld_done) |-> ld_last)
    else $error("text end flagged on a result that is not the last of its run");

endmodule

/* src/ansi_csi_sequence_stripper_top.sv */
// ----------------------------------------------------------------------------
// ANSI CSI sequence stripper
// Removes ESC '[' ... 'K'/'m' sequences from a byte stream.
// ----------------------------------------------------------------------------
// A byte that passes straight through, or is held as part of a candidate
// sequence, is taken by the parser, and results leave one per cycle from an
// output register while the output is not stalled, with a four-entry command
// queue between the parser and the output side. When a sequence is released
// (broken, too long or cut off by the end of the text), the output side first
// issues the read of the hold RAM's first entry, then loads the n held bytes
// one per cycle through its single read port while the output is free, then
// the breaking byte if there is one, and input is stalled from the release
// until its last byte has been loaded into the output register.
module ansi_csi_sequence_stripper_top
  import acs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  acs_in_if.sink    in_chan,
  acs_out_if.source out_chan
);

  logic               push, pop, q_full, q_empty, rel_done;
  cmd_t               push_cmd, head;
  logic               ram_we, ram_re;
  logic [HOLD_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  acs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .rel_done  (rel_done),
    .push      (push),
    .push_cmd  (push_cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  acs_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  acs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_HOLD)
  ) u_hold_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  acs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .rel_done  (rel_done),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_chan  (out_chan)
  );

endmodule

/* tb/ansi_csi_strip_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI stripper checker
// Watches both channels. Each accepted input byte is run through a
// behavioural stripper that yields the results it should cause. Each
// accepted output transaction is compared with the oldest one still
// outstanding. Mismatches and unexpected results are counted for the top.
// ----------------------------------------------------------------------------
module ansi_csi_strip_checker
  import acs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  acs_in_if    in_mon,
  acs_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [2:0] {
    PM_SEARCH, PM_ESC, PM_PARAM, PM_INTER, PM_PASS
  } parse_mode_e;

  typedef enum logic [1:0] {
    V_HOLD, V_DONE, V_BREAK
  } verdict_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
    logic       hold_overflow;
  } strip_res_t;

  parse_mode_e mode;
  logic [7:0]  held [MAX_HOLD];
  int          held_n;
  strip_res_t  step_q [$];
  strip_res_t  stripped_q [$];

  task automatic put_byte(input logic [7:0] b, input logic ov);
    strip_res_t r;
    r = '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, text_done: 1'b0,
          hold_overflow: ov};
    step_q.push_back(r);
  endtask

  task automatic release_held(input logic ov);
    for (int i = 0; i < held_n; i++) put_byte(held[i], ov);
    held_n = 0;
  endtask

  task automatic strip_step(input logic [7:0] b, input logic text_end);
    verdict_e vd;
    strip_res_t r;
    step_q.delete();
    case (mode)
      PM_SEARCH: begin
        if (b == CH_ESC) begin
          held[0] = b;
          held_n  = 1;
          mode    = PM_ESC;
        end else begin
          put_byte(b, 1'b0);
        end
      end
      PM_PASS: put_byte(b, 1'b0);
      default: begin
        vd = V_BREAK;
        if (mode == PM_ESC) begin
          if (b == CH_BRACKET) begin
            vd   = V_HOLD;
            mode = PM_PARAM;
          end
        end else if (mode == PM_PARAM && b >= CH_PARAM_LO && b <= CH_PARAM_HI) begin
          vd = V_HOLD;
        end else if (b >= CH_INTER_LO && b <= CH_INTER_HI) begin
          vd   = V_HOLD;
          mode = PM_INTER;
        end else if (b == CH_FINAL_K || b == CH_FINAL_M) begin
          vd = V_DONE;
        end
        if (vd != V_BREAK && held_n >= MAX_HOLD) begin
          release_held(1'b1);
          put_byte(b, 1'b1);
          mode = PM_PASS;
        end else if (vd == V_HOLD) begin
          held[held_n] = b;
          held_n++;
        end else if (vd == V_DONE) begin
          held_n = 0;
          mode   = PM_SEARCH;
        end else begin
          release_held(1'b0);
          put_byte(b, 1'b0);
          mode = PM_PASS;
        end
      end
    endcase
    if (text_end) begin
      if (mode == PM_ESC || mode == PM_PARAM || mode == PM_INTER) release_held(1'b0);
      if (step_q.size() == 0) begin
        r = '0;
        step_q.push_back(r);
      end
      step_q[step_q.size()-1].text_done = 1'b1;
      mode   = PM_SEARCH;
      held_n = 0;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
    foreach (step_q[i]) stripped_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    strip_res_t got;
    strip_res_t want;
    if (rst) begin
      mode = PM_SEARCH;
      held_n = 0;
      stripped_q.delete();
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) strip_step(in_mon.in_byte, in_mon.text_end);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_byte: out_mon.out_byte, byte_valid: out_mon.byte_valid,
                run_last: out_mon.run_last, text_done: out_mon.text_done,
                hold_overflow: out_mon.hold_overflow};
        if (stripped_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got byte=%h valid=%b last=%b done=%b ov=%b",
                   $time, got.out_byte, got.byte_valid, got.run_last, got.text_done,
                   got.hold_overflow);
          fail_count <= fail_count + 1;
        end else begin
          want = stripped_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected byte=%h valid=%b last=%b done=%b ov=%b",
                     $time, want.out_byte, want.byte_valid, want.run_last, want.text_done,
                     want.hold_overflow);
            $display("%0t:                  actual   byte=%h valid=%b last=%b done=%b ov=%b",
                     $time, got.out_byte, got.byte_valid, got.run_last, got.text_done,
                     got.hold_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= stripped_q.size();
  end

endmodule

/* tb/ansi_csi_sequence_stripper_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI CSI sequence stripper testbench
// Drives texts made of plain bytes and complete, broken, over-long and
// cut-off escape sequences, with random gaps on the input and random stalls
// on the output. Results are checked by a separate checker; this module
// makes the stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module ansi_csi_sequence_stripper_top_tb
  import acs_pkg::*;
();

  localparam int TARGET_BYTES   = 380;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum logic [1:0] {TAIL_FINAL, TAIL_BREAK, TAIL_NONE} csi_tail_e;

  logic       clk;
  logic       rst;
  logic       in_gaps;
  logic       out_gaps;
  int         bytes_sent;
  int         stall_cycles;
  int         fail_count;
  int         pending;
  logic [7:0] text_q [$];

  acs_in_if  in_chan ();
  acs_out_if out_chan ();

  ansi_csi_sequence_stripper_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ansi_csi_strip_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= !out_gaps || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic text_end);
    logic taken;
    while (in_gaps && $urandom_range(99) < 33) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.in_byte  <= b;
    in_chan.text_end <= text_end;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_chan.ready;
      @(negedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) begin
      in_gaps  = !(bytes_sent >= 120 && bytes_sent < 220);
      out_gaps = in_gaps;
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic push_csi(input int body_len, input csi_tail_e tail);
    int n_param;
    n_param = $urandom_range(body_len, 0);
    text_q.push_back(CH_ESC);
    text_q.push_back(CH_BRACKET);
    repeat (n_param) text_q.push_back(8'($urandom_range(CH_PARAM_HI, CH_PARAM_LO)));
    repeat (body_len - n_param)
      text_q.push_back(8'($urandom_range(CH_INTER_HI, CH_INTER_LO)));
    case (tail)
      TAIL_FINAL: text_q.push_back($urandom_range(1) ? CH_FINAL_K : CH_FINAL_M);
      TAIL_BREAK: text_q.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    int pick;
    rst              = 1'b1;
    in_gaps          = 1'b1;
    out_gaps         = 1'b1;
    bytes_sent       = 0;
    in_chan.valid    = 1'b0;
    in_chan.in_byte  = 8'h00;
    in_chan.text_end = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    text_q = '{8'h00, 8'hff};
    send_text();
    text_q = '{CH_ESC, CH_BRACKET, CH_PARAM_LO, CH_PARAM_HI, CH_INTER_LO, CH_INTER_HI,
               CH_FINAL_M};
    send_text();
    text_q = '{CH_ESC, CH_BRACKET, CH_FINAL_K};
    send_text();
    text_q = '{CH_ESC, CH_ESC, 8'h41};
    send_text();
    text_q = '{CH_ESC, CH_BRACKET, 8'h35};
    send_text();
    text_q = '{CH_ESC};
    send_text();
    text_q = '{CH_ESC, CH_BRACKET, 8'h31, 8'h78};
    send_text();

    while (bytes_sent < TARGET_BYTES) begin
      repeat ($urandom_range(5, 1)) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom));
        end else if (pick < 60) begin
          push_csi($urandom_range(5, 0), TAIL_FINAL);
        end else if (pick < 72) begin
          push_csi($urandom_range(5, 0), TAIL_BREAK);
        end else if (pick < 82) begin
          push_csi($urandom_range(32, 28), TAIL_FINAL);
        end else if (pick < 90) begin
          push_csi($urandom_range(4, 0), TAIL_NONE);
        end else begin
          text_q.push_back(CH_ESC);
          text_q.push_back(8'($urandom));
        end
      end
      send_text();
    end
    in_chan.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
